### hw/rtl/tdp_pkg.sv
// Shared types for the trial-division prime test unit.
package tdp_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new candidate, restart the divisor at two
    logic div_start;  // begin a remainder computation for the current divisor
    logic div_step;   // one restoring-division step
    logic next_div;   // advance the divisor and its square
    logic out_load;   // load the result register
    logic out_prime;  // verdict written with out_load
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic below_two;  // candidate is zero or one
    logic sq_above;   // divisor squared exceeds the candidate
    logic div_last;   // current division step is the final one
    logic rem_zero;   // remainder of the finished division is zero
  } sts_t;

endpackage

### hw/rtl/tdp_datapath.sv
// Datapath: candidate, divisor, divisor square, serial remainder and result register.
module tdp_datapath #(
  parameter int NUMBER_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdp_pkg::cmd_t          cmd_i,
  output tdp_pkg::sts_t          sts_o,
  input  logic [NUMBER_BITS-1:0] candidate_i,
  output logic [NUMBER_BITS-1:0] number_o,
  output logic                   is_prime_o
);

  // Divisor never exceeds the integer root plus one; its square fits one extra bit.
  localparam int DW = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SW = NUMBER_BITS + 1;
  localparam int CW = $clog2(NUMBER_BITS + 1);

  logic [NUMBER_BITS-1:0] n_q, n_d;
  logic [DW-1:0]          div_q, div_d;
  logic [SW-1:0]          sq_q, sq_d;
  logic [DW-1:0]          rem_q, rem_d;
  logic [NUMBER_BITS-1:0] sh_q, sh_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [NUMBER_BITS-1:0] number_q, number_d;
  logic                   prime_q, prime_d;

  logic [DW:0] rem_sh;
  logic [DW:0] div_ext;
  logic [DW:0] rem_sub;

  // One restoring-division step: shift in the next candidate bit, subtract if it fits.
  assign rem_sh  = {rem_q, sh_q[NUMBER_BITS-1]};
  assign div_ext = {1'b0, div_q};
  assign rem_sub = rem_sh - div_ext;

  always_comb begin
    n_d      = n_q;
    div_d    = div_q;
    sq_d     = sq_q;
    rem_d    = rem_q;
    sh_d     = sh_q;
    cnt_d    = cnt_q;
    number_d = number_q;
    prime_d  = prime_q;
    if (cmd_i.load) begin
      n_d   = candidate_i;
      div_d = DW'(2);
      sq_d  = SW'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      sh_d  = n_q;
      cnt_d = CW'(NUMBER_BITS);
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= div_ext) begin
        rem_d = rem_sub[DW-1:0];
      end else begin
        rem_d = rem_sh[DW-1:0];
      end
      sh_d  = {sh_q[NUMBER_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
    end
    // (d+1)^2 = d^2 + 2d + 1.
    if (cmd_i.next_div) begin
      div_d = div_q + DW'(1);
      sq_d  = sq_q + SW'({div_q, 1'b1});
    end
    if (cmd_i.out_load) begin
      number_d = n_q;
      prime_d  = cmd_i.out_prime;
    end
  end

  // Control counter under reset; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    div_q    <= div_d;
    sq_q     <= sq_d;
    rem_q    <= rem_d;
    sh_q     <= sh_d;
    number_q <= number_d;
    prime_q  <= prime_d;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.below_two = (n_q < NUMBER_BITS'(2));
    sts_o.sq_above  = (sq_q > {1'b0, n_q});
    sts_o.div_last  = (cnt_q == CW'(1));
    sts_o.rem_zero  = (rem_q == '0);
  end

  assign number_o   = number_q;
  assign is_prime_o = prime_q;

endmodule

### hw/rtl/tdp_controller.sv
// Controller: sequences the divisor sweep and owns both handshakes.
module tdp_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tdp_pkg::cmd_t cmd_o,
  input  tdp_pkg::sts_t sts_i
);

  tdp_pkg::state_e state_q, state_d;
  logic            verdict_q, verdict_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdp_pkg::ST_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    // A taken result frees the output register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tdp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_CHECK: begin
        if (sts_i.below_two) begin
          verdict_d = 1'b0;
          state_d   = tdp_pkg::ST_FINISH;
        end else if (sts_i.sq_above) begin
          verdict_d = 1'b1;
          state_d   = tdp_pkg::ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tdp_pkg::ST_DIVIDE;
        end
      end
      tdp_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = tdp_pkg::ST_TEST;
        end
      end
      tdp_pkg::ST_TEST: begin
        if (sts_i.rem_zero) begin
          verdict_d = 1'b0;
          state_d   = tdp_pkg::ST_FINISH;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_FINISH: begin
        // Wait until the output register is empty or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_prime = verdict_q;
          out_valid_d     = 1'b1;
          state_d         = tdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/trial_division_prime_test_unit.sv
// Trial-division prime test unit: top level joining controller and datapath.
//
// Usage: present a candidate on candidate_i with in_valid_i; the transaction
// completes when in_ready_o is also high. One result transaction follows on
// number_o (the candidate echoed) and is_prime_o, held with out_valid_o until
// out_ready_i is high. Candidates zero and one are reported not prime.
//
// Sequence: the unit works on one candidate at a time. Each divisor tried
// passes a check state, serial remainder steps (one per candidate bit) and
// a test state; divisors run from two up to the integer square root,
// stopping at the first exact divisor.
//
// Reset clears the controller and the result valid flag; nothing else needs
// clearing. If the receiver stalls, the finished result waits in the output
// register; the next candidate is accepted meanwhile, and its own result waits
// in the controller until the output register frees.
module trial_division_prime_test_unit #(
  parameter int NUMBER_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] candidate_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NUMBER_BITS-1:0] number_o,
  output logic                   is_prime_o
);

  tdp_pkg::cmd_t cmd;
  tdp_pkg::sts_t sts;

  tdp_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tdp_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .candidate_i (candidate_i),
    .number_o    (number_o),
    .is_prime_o  (is_prime_o)
  );

endmodule

### test/trial_division_prime_test_unit_tb.sv
// Self-checking testbench for the trial-division prime test unit.
`timescale 1ns / 100ps

module trial_division_prime_test_unit_tb;

  localparam int NB = 20;
  // The slowest candidate (a prime near the top of the range) sees no
  // transaction on either side while it runs, so allow a wide margin.
  localparam int IDLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 81;

  typedef struct {
    bit [NB-1:0] number;
    bit          is_prime;
  } verdict_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [NB-1:0] candidate_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [NB-1:0] number_o;
  logic          is_prime_o;

  bit [NB-1:0] candidates_pending[$];
  verdict_t    verdicts_due[$];

  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          errors = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          primes_seen = 0;
  int          idle_cycles = 0;

  trial_division_prime_test_unit #(
    .NUMBER_BITS(NB)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .number_o   (number_o),
    .is_prime_o (is_prime_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Primality by trial division up to the integer square root.
  function automatic bit trial_prime(bit [NB-1:0] n);
    longint unsigned d;
    if (n < 2) begin
      return 1'b0;
    end
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Candidate driver: holds each transaction until accepted, then idles for
  // a drawn number of cycles before the next one.
  always @(posedge clk_i) begin : drive_candidates
    verdict_t v;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        v.number = candidate_i;
        v.is_prime = trial_prime(candidate_i);
        verdicts_due.push_back(v);
        sent_count++;
      end
      if (in_valid_i && !in_ready_o) begin
        // Transaction still waiting; keep valid and payload as they are.
      end else if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
        in_valid_i <= 1'b0;
      end else if (candidates_pending.size() != 0) begin
        candidate_i <= candidates_pending.pop_front();
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          tx_burst = !tx_burst;
        end
        tx_wait <= tx_burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: compares each result transaction with the oldest verdict
  // due and stalls the output side for a drawn number of cycles afterwards.
  always @(posedge clk_i) begin : check_results
    verdict_t    due;
    int unsigned stall;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: number %0d, is_prime %0d", number_o, is_prime_o);
          errors++;
        end else begin
          due = verdicts_due.pop_front();
          if (number_o !== due.number) begin
            $error("number: expected %0d, actual %0d", due.number, number_o);
            errors++;
          end
          if (is_prime_o !== due.is_prime) begin
            $error("is_prime for %0d: expected %0d, actual %0d",
                   due.number, due.is_prime, is_prime_o);
            errors++;
          end
          checked_count++;
          if (due.is_prime) begin
            primes_seen++;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          rx_burst = !rx_burst;
        end
        stall = rx_burst ? 0 : $urandom_range(0, 15);
        rx_wait <= stall;
        out_ready_i <= (stall == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_ready_i <= (rx_wait == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("trial_division_prime_test_unit_tb: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned r;
    int unsigned a;
    int unsigned b;

    // Directed: zero and one, two and three, small primes and squares,
    // field extremes, alternating bit patterns, the largest 20-bit prime,
    // a square of a prime near the top and a semiprime with close factors.
    candidates_pending = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121,
                           20'hFFFFF, 20'hAAAAA, 20'h55555, 65536,
                           524287, 1048573, 1042441, 1022117};

    // Random: mostly small candidates, some across the full range, and
    // squares and products of two factors, each drawn from 2 to 1023.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        candidates_pending.push_back(NB'($urandom_range(0, 4095)));
      end else if (r < 7) begin
        candidates_pending.push_back(NB'($urandom_range(0, 65535)));
      end else if (r < 9) begin
        candidates_pending.push_back(NB'($urandom));
      end else begin
        a = $urandom_range(2, 1023);
        b = $urandom_range(0, 1) ? a : $urandom_range(2, 1023);
        candidates_pending.push_back(NB'(a * b));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (candidates_pending.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (verdicts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (verdicts_due.size() != 0) begin
      $error("%0d results still outstanding at end of run", verdicts_due.size());
      errors++;
    end

    $display("Tested %0d candidates, %0d results checked: %0d prime, %0d not prime.",
             sent_count, checked_count, primes_seen, checked_count - primes_seen);
    $display("Covered zero and one, two and three, perfect squares and 20-bit extremes.");
    if (errors == 0) begin
      $display("trial_division_prime_test_unit_tb: done, clean");
    end else begin
      $display("trial_division_prime_test_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
